// ===== rtl/core/point_in_polygon_test_core_assert.svh =====
// assertion macros shared by the core
`ifndef POINT_IN_POLYGON_TEST_CORE_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_CORE_ASSERT_SVH

// same-cycle implication
`define PIPT_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("point in polygon core: assertion failed");

// next-cycle implication
`define PIPT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("point in polygon core: assertion failed");

`endif

// ===== rtl/core/pipt_pkg.sv =====
package pipt_pkg;

   localparam int FIELD_W = 24;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LAST,
      OP_FIRST,
      OP_HIST,
      OP_LOADB,
      OP_EDGE
   } pipt_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_LAST,
      ST_RD_FIRST,
      ST_WAIT,
      ST_SETUP,
      ST_PRE,
      ST_MAIN_B,
      ST_MAIN,
      ST_DRAIN,
      ST_FINISH
   } pipt_state_type;

   typedef enum logic [1:0] {
      K_SKIP,
      K_BORDER,
      K_TOGGLE,
      K_MULT
   } pipt_kind_type;

   typedef struct packed {
      pipt_op_type op;
      logic        start;
      logic        load_rsp;
   } pipt_cmd_type;

   typedef struct packed {
      logic closed;
      logic busy;
      logic rsp_free;
   } pipt_status_type;

endpackage

// ===== rtl/core/pipt_ctrl.sv =====
module pipt_ctrl
   import pipt_pkg::*;
#(
   parameter int MAX_VERTICES = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_cmd,
   input  logic [$clog2(MAX_VERTICES+1)-1:0] count,
   input  pipt_status_type                   status,
   output logic                              req_ready,
   output pipt_cmd_type                      cmd,
   output logic [$clog2(MAX_VERTICES)-1:0]   rd_addr
);

   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int AW    = $clog2(MAX_VERTICES);

   pipt_state_type   state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] edges_ff, edges_in;
   logic [CNT_W-1:0] cnt_m1;
   logic [CNT_W-1:0] edges_m1;

   assign cnt_m1   = count - CNT_W'(1);
   assign edges_m1 = edges_ff - CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         edges_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         edges_ff <= edges_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      edges_in = edges_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_cmd) begin
               state_in = (count == '0) ? ST_FINISH : ST_RD_LAST;
            end
         end
         ST_RD_LAST:  state_in = ST_RD_FIRST;
         ST_RD_FIRST: state_in = ST_WAIT;
         ST_WAIT:     state_in = ST_SETUP;
         ST_SETUP: begin
            edges_in = status.closed ? cnt_m1 : count;
            idx_in   = '0;
            state_in = (status.closed && count == CNT_W'(1)) ? ST_DRAIN : ST_PRE;
         end
         ST_PRE: begin
            if (idx_ff == edges_m1) begin
               state_in = ST_MAIN_B;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_MAIN_B: begin
            idx_in   = CNT_W'(1);
            state_in = ST_MAIN;
         end
         ST_MAIN: begin
            if (idx_ff == edges_ff) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!status.busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.op       = OP_NONE;
      cmd.start    = 1'b0;
      cmd.load_rsp = 1'b0;
      rd_addr      = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid && req_cmd;
         end
         ST_RD_LAST: begin
            cmd.op  = OP_LAST;
            rd_addr = cnt_m1[AW-1:0];
         end
         ST_RD_FIRST: begin
            cmd.op = OP_FIRST;
         end
         ST_PRE: begin
            cmd.op  = OP_HIST;
            rd_addr = idx_ff[AW-1:0];
         end
         ST_MAIN_B: begin
            cmd.op = OP_LOADB;
         end
         ST_MAIN: begin
            cmd.op  = OP_EDGE;
            rd_addr = (idx_ff == count) ? '0 : idx_ff[AW-1:0];
         end
         ST_FINISH: begin
            cmd.load_rsp = status.rsp_free;
         end
         default: begin
            cmd.op = OP_NONE;
         end
      endcase
   end

endmodule

// ===== rtl/core/pipt_datapath.sv =====
module pipt_datapath
   import pipt_pkg::*;
#(
   parameter int MAX_VERTICES = 256,
   parameter int COORD_WIDTH  = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_accept,
   input  logic                              req_cmd,
   input  logic                              req_restart,
   input  logic [FIELD_W-1:0]                req_x,
   input  logic [FIELD_W-1:0]                req_y,
   input  pipt_cmd_type                      cmd,
   input  logic [$clog2(MAX_VERTICES)-1:0]   rd_addr,
   input  logic                              rsp_ready,
   output logic [$clog2(MAX_VERTICES+1)-1:0] count,
   output pipt_status_type                   status,
   output logic                              rsp_valid,
   output logic                              rsp_inside,
   output logic                              rsp_empty,
   output logic                              rsp_ovf
);

   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int AW     = $clog2(MAX_VERTICES);
   localparam int CW     = COORD_WIDTH;
   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int PROD_W = 2 * COORD_WIDTH;
   localparam int EXT_W  = FIELD_W + COORD_WIDTH;

   logic signed [CW-1:0] mem_x [MAX_VERTICES];
   logic signed [CW-1:0] mem_y [MAX_VERTICES];

   logic [EXT_W-1:0]     ext_x, ext_y;
   logic signed [CW-1:0] vx, vy;

   logic [CNT_W-1:0] count_ff, count_in, base;
   logic             ovf_ff, ovf_in;
   logic             wr_en;

   logic signed [CW-1:0] rd_x_ff, rd_y_ff;
   pipt_op_type          op_ff;
   logic signed [CW-1:0] px_ff, py_ff;
   logic signed [CW-1:0] last_x_ff, last_y_ff;
   logic                 closed_ff;
   logic signed [CW-1:0] vb_x_ff, vb_y_ff;

   logic signed [CW-1:0] cur_ff, alt_ff, hist_y;
   logic                 cur_v_ff, alt_v_ff, hist_en;

   logic signed [CW-1:0]     xb, yb, xe, ye, x1, x2, ylo, yhi, xlo, xhi, yprev;
   logic signed [DIFF_W-1:0] dx, du, ddy, da;
   logic [CW-1:0]            mag_d, mag_u;
   pipt_kind_type            kind;

   logic                 s1_v_ff, s1_pos_ff;
   pipt_kind_type        s1_kind_ff;
   logic [CW-1:0]        s1_dy_ff, s1_a_ff, s1_d_ff, s1_u_ff;
   logic                 s2_v_ff, s2_pos_ff;
   logic [PROD_W-1:0]    s2_p_ff, s2_q_ff;
   logic                 s2_neg;

   logic border_ff, parity_ff;
   logic rsp_valid_ff, rsp_inside_ff, rsp_empty_ff, rsp_ovf_ff;

   assign ext_x = {{COORD_WIDTH{1'b0}}, req_x};
   assign ext_y = {{COORD_WIDTH{1'b0}}, req_y};
   assign vx    = ext_x[CW-1:0];
   assign vy    = ext_y[CW-1:0];

   // vertex append
   always_comb begin
      base     = req_restart ? '0 : count_ff;
      wr_en    = 1'b0;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (req_accept && !req_cmd) begin
         if (req_restart) begin
            ovf_in = 1'b0;
         end
         if (base < CNT_W'(MAX_VERTICES)) begin
            wr_en    = 1'b1;
            count_in = base + CNT_W'(1);
         end else begin
            count_in = base;
            ovf_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[base[AW-1:0]] <= vx;
         mem_y[base[AW-1:0]] <= vy;
      end
      rd_x_ff <= mem_x[rd_addr];
      rd_y_ff <= mem_y[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         op_ff    <= OP_NONE;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         op_ff    <= cmd.op;
      end
   end

   // vertex history for the nearest earlier vertex with a different y
   always_comb begin
      hist_en = 1'b0;
      hist_y  = rd_y_ff;
      case (op_ff)
         OP_HIST: hist_en = 1'b1;
         OP_EDGE: begin
            hist_en = 1'b1;
            hist_y  = vb_y_ff;
         end
         default: hist_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         px_ff <= vx;
         py_ff <= vy;
      end
      if (op_ff == OP_LAST) begin
         last_x_ff <= rd_x_ff;
         last_y_ff <= rd_y_ff;
      end
      if (op_ff == OP_FIRST) begin
         closed_ff <= (rd_x_ff == last_x_ff) && (rd_y_ff == last_y_ff);
      end
      if (op_ff == OP_LOADB || op_ff == OP_EDGE) begin
         vb_x_ff <= rd_x_ff;
         vb_y_ff <= rd_y_ff;
      end
      if (hist_en && (!cur_v_ff || hist_y != cur_ff)) begin
         cur_ff <= hist_y;
         alt_ff <= cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.start) begin
         cur_v_ff <= 1'b0;
         alt_v_ff <= 1'b0;
      end else if (hist_en && (!cur_v_ff || hist_y != cur_ff)) begin
         cur_v_ff <= 1'b1;
         alt_v_ff <= cur_v_ff;
      end
   end

   // edge classification
   always_comb begin
      xb = vb_x_ff;
      yb = vb_y_ff;
      xe = rd_x_ff;
      ye = rd_y_ff;
      if (ye <= yb) begin
         x1 = xe; ylo = ye; x2 = xb; yhi = yb;
      end else begin
         x1 = xb; ylo = yb; x2 = xe; yhi = ye;
      end
      if (xe >= xb) begin
         xhi = xe; xlo = xb;
      end else begin
         xhi = xb; xlo = xe;
      end
      if (cur_v_ff && cur_ff != yb) begin
         yprev = cur_ff;
      end else if (alt_v_ff) begin
         yprev = alt_ff;
      end else begin
         yprev = yb;
      end
      dx    = DIFF_W'(x2) - DIFF_W'(x1);
      du    = DIFF_W'(px_ff) - DIFF_W'(x1);
      ddy   = DIFF_W'(yhi) - DIFF_W'(ylo);
      da    = DIFF_W'(py_ff) - DIFF_W'(ylo);
      mag_d = (dx < 0) ? CW'(-dx) : CW'(dx);
      mag_u = (du < 0) ? CW'(-du) : CW'(du);
      if (ylo > py_ff || yhi < py_ff || xhi < px_ff) begin
         kind = K_SKIP;
      end else if (yhi == ylo) begin
         kind = (px_ff >= xlo) ? K_BORDER : K_SKIP;
      end else if (yb == py_ff) begin
         if (xb < px_ff) begin
            kind = K_SKIP;
         end else if (xb == px_ff) begin
            kind = K_BORDER;
         end else if ((yprev >= yb && ye > yb) || (yprev < yb && ye <= yb)) begin
            kind = K_TOGGLE;
         end else begin
            kind = K_SKIP;
         end
      end else if (xlo > px_ff || x2 == x1) begin
         kind = K_TOGGLE;
      end else begin
         kind = K_MULT;
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff <= kind;
      s1_dy_ff   <= ddy[CW-1:0];
      s1_a_ff    <= da[CW-1:0];
      s1_d_ff    <= mag_d;
      s1_u_ff    <= mag_u;
      s1_pos_ff  <= x2 > x1;
      s2_p_ff    <= PROD_W'(s1_dy_ff) * PROD_W'(s1_u_ff);
      s2_q_ff    <= PROD_W'(s1_a_ff) * PROD_W'(s1_d_ff);
      s2_pos_ff  <= s1_pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= op_ff == OP_EDGE;
         s2_v_ff <= s1_v_ff && s1_kind_ff == K_MULT;
      end
   end

   assign s2_neg = s2_pos_ff ? (s2_p_ff < s2_q_ff) : (s2_q_ff < s2_p_ff);

   always_ff @(posedge clock) begin
      if (reset || cmd.start) begin
         border_ff <= 1'b0;
         parity_ff <= 1'b0;
      end else begin
         if ((s1_v_ff && s1_kind_ff == K_BORDER) || (s2_v_ff && s2_p_ff == s2_q_ff)) begin
            border_ff <= 1'b1;
         end
         parity_ff <= parity_ff ^ (s1_v_ff && s1_kind_ff == K_TOGGLE)
                      ^ (s2_v_ff && s2_p_ff != s2_q_ff && s2_neg);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_inside_ff <= border_ff | parity_ff;
         rsp_empty_ff  <= count_ff == '0;
         rsp_ovf_ff    <= ovf_ff;
      end
   end

   assign count           = count_ff;
   assign status.closed   = closed_ff;
   assign status.busy     = (op_ff != OP_NONE) || s1_v_ff || s2_v_ff;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_inside      = rsp_inside_ff;
   assign rsp_empty       = rsp_empty_ff;
   assign rsp_ovf         = rsp_ovf_ff;

endmodule

// ===== rtl/core/point_in_polygon_test_core.sv =====
// vertex append: one transaction per cycle while the core is idle; appends stall during a query
// query over E edges: one query at a time
// a query makes a history pass and then an edge pass through the single read port of the vertex memory
// a finished result waits in the output register while appends are taken
// reset (synchronous, active high) empties the polygon and clears the overflow flag
module point_in_polygon_test_core
   import pipt_pkg::*;
#(
   parameter int MAX_VERTICES = 256,
   parameter int COORD_WIDTH  = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // coord_x, coord_y
   input  logic [1:0]  req_tuser,   // cmd, restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // inside_res, polygon_empty, vertex_overflow, zero fill
);

   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int AW    = $clog2(MAX_VERTICES);

   pipt_cmd_type    cmd;
   pipt_status_type status;
   logic [CNT_W-1:0] count;
   logic [AW-1:0]    rd_addr;
   logic             req_accept;
   logic             rsp_inside, rsp_empty, rsp_ovf;

   assign req_accept = req_tvalid && req_tready;

   pipt_ctrl #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_cmd   (req_tuser[0]),
      .count     (count),
      .status    (status),
      .req_ready (req_tready),
      .cmd       (cmd),
      .rd_addr   (rd_addr)
   );

   pipt_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_WIDTH  (COORD_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_accept),
      .req_cmd     (req_tuser[0]),
      .req_restart (req_tuser[1]),
      .req_x       (req_tdata[23:0]),
      .req_y       (req_tdata[47:24]),
      .cmd         (cmd),
      .rd_addr     (rd_addr),
      .rsp_ready   (rsp_tready),
      .count       (count),
      .status      (status),
      .rsp_valid   (rsp_tvalid),
      .rsp_inside  (rsp_inside),
      .rsp_empty   (rsp_empty),
      .rsp_ovf     (rsp_ovf)
   );

   assign rsp_tdata = {5'b0, rsp_ovf, rsp_empty, rsp_inside};

`include "point_in_polygon_test_core_assert.svh"

   `PIPT_ASSERT_NEXT(a_query_holds_input, clock, reset, req_tvalid && req_tready && req_tuser[0], !req_tready)
   `PIPT_ASSERT_SAME(a_empty_not_inside, clock, reset, rsp_tvalid && rsp_tdata[1], !rsp_tdata[0])
   `PIPT_ASSERT_SAME(a_result_after_query, clock, reset, $rose(rsp_tvalid), !$past(req_tready))

endmodule
